[rtl/core/jfhs_pkg.sv]
`default_nettype none

package jfhs_pkg;

	localparam int POSITION_BITS_DEF = 32;

	localparam logic [7:0] BYTE_PREFIX = 8'hFF;
	localparam logic [7:0] BYTE_SOI    = 8'hD8;
	localparam logic [7:0] CODE_SOF0   = 8'hC0;
	localparam logic [7:0] CODE_SOF1   = 8'hC1;
	localparam logic [7:0] CODE_SOF2   = 8'hC2;

	localparam logic [31:0] MIN_FILE_SIZE = 32'd11;
	localparam logic [15:0] MIN_SEG_LEN   = 16'd2;
	localparam logic [15:0] MIN_SOF_LEN   = 16'd7;

	typedef enum logic [2:0] {
		STS_FOUND     = 3'd0,
		STS_NO_SOI    = 3'd1,
		STS_NO_PREFIX = 3'd2,
		STS_BAD_LEN   = 3'd3,
		STS_TRUNC     = 3'd4
	} status_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] height;
		logic [15:0] width;
	} result_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
	} in_item_t;

endpackage

`default_nettype wire

[rtl/core/jfhs_in_reg.sv]
`default_nettype none

module jfhs_in_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire jfhs_pkg::in_item_t in_item,
	input  wire logic              take,
	output logic                   valid_s1,
	output jfhs_pkg::in_item_t     item_s1
);

	// a new item may enter whenever the held one leaves this cycle
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

`default_nettype wire

[rtl/core/jfhs_parse.sv]
`default_nettype none

module jfhs_parse #(
	parameter int POSITION_BITS = jfhs_pkg::POSITION_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [31:0]        cfg_wr_data,
	input  wire logic               step,
	input  wire jfhs_pkg::in_item_t item_s1,
	output logic                    fin,
	output jfhs_pkg::result_t       result
);

	localparam int CmpW = ((POSITION_BITS > 32) ? POSITION_BITS : 32) + 2;

	localparam logic [15:0] MIN_SEG_LEN_W = jfhs_pkg::MIN_SEG_LEN;

	localparam logic [2:0] IDX_HEIGHT_HI = 3'd1;
	localparam logic [2:0] IDX_HEIGHT_LO = 3'd2;
	localparam logic [2:0] IDX_WIDTH_HI  = 3'd3;
	localparam logic [2:0] IDX_WIDTH_LO  = 3'd4;

	typedef enum logic [3:0] {
		PH_START0,
		PH_START1,
		PH_MARK0,
		PH_MARK1,
		PH_LEN0,
		PH_LEN1,
		PH_SKIP,
		PH_SOF
	} phase_t;

	logic [31:0]              file_size_q;
	phase_t                   phase_q, eff_phase, phase_d;
	logic [POSITION_BITS-1:0] pos_q, eff_pos, pos_d, next_pos;
	logic [7:0]               marker_q, eff_marker, marker_d;
	logic [15:0]              len_q, eff_len, len_d, len_full;
	logic [15:0]              skip_q, eff_skip, skip_d, skip_dec;
	logic [2:0]               idx_q, eff_idx, idx_d;
	logic [15:0]              height_q, eff_height, height_d;
	logic [15:0]              width_q, eff_width, width_d;
	logic                     done_q, eff_done, done_d;
	logic                     room_ok, pad_ok, len_fits, is_sof;
	logic [7:0]               b;

	assign b        = item_s1.data_byte;
	assign next_pos = eff_pos + POSITION_BITS'(1);
	assign len_full = {eff_len[15:8], b};
	assign skip_dec = eff_skip - 16'd1;

	// remaining-byte checks against the configured file size
	assign room_ok  = (CmpW'(next_pos) + CmpW'(4)) <= CmpW'(file_size_q);
	assign pad_ok   = (CmpW'(next_pos) + CmpW'(3)) <= CmpW'(file_size_q);
	assign len_fits = (CmpW'(next_pos) + CmpW'(len_full - MIN_SEG_LEN_W))
		< CmpW'(file_size_q);

	always_comb begin
		is_sof = eff_marker inside {jfhs_pkg::CODE_SOF0, jfhs_pkg::CODE_SOF1,
			jfhs_pkg::CODE_SOF2};
	end

	always_comb begin
		// a first byte restarts the scan before it is parsed
		if (item_s1.first_byte) begin
			eff_phase  = PH_START0;
			eff_pos    = '0;
			eff_marker = '0;
			eff_len    = '0;
			eff_skip   = '0;
			eff_idx    = '0;
			eff_height = '0;
			eff_width  = '0;
			eff_done   = 1'b0;
		end else begin
			eff_phase  = phase_q;
			eff_pos    = pos_q;
			eff_marker = marker_q;
			eff_len    = len_q;
			eff_skip   = skip_q;
			eff_idx    = idx_q;
			eff_height = height_q;
			eff_width  = width_q;
			eff_done   = done_q;
		end
	end

	always_comb begin
		phase_d       = eff_phase;
		pos_d         = eff_pos;
		marker_d      = eff_marker;
		len_d         = eff_len;
		skip_d        = eff_skip;
		idx_d         = eff_idx;
		height_d      = eff_height;
		width_d       = eff_width;
		done_d        = eff_done;
		fin           = 1'b0;
		result.status = jfhs_pkg::STS_FOUND;
		result.height = '0;
		result.width  = '0;
		if (!eff_done) begin
			pos_d = next_pos;
			case (eff_phase)
				PH_START0: begin
					if (file_size_q < jfhs_pkg::MIN_FILE_SIZE) begin
						fin           = 1'b1;
						result.status = jfhs_pkg::STS_TRUNC;
					end else if (b != jfhs_pkg::BYTE_PREFIX) begin
						fin           = 1'b1;
						result.status = jfhs_pkg::STS_NO_SOI;
					end else begin
						phase_d = PH_START1;
					end
				end
				PH_START1: begin
					if (b != jfhs_pkg::BYTE_SOI) begin
						fin           = 1'b1;
						result.status = jfhs_pkg::STS_NO_SOI;
					end else if (!room_ok) begin
						fin           = 1'b1;
						result.status = jfhs_pkg::STS_TRUNC;
					end else begin
						phase_d = PH_MARK0;
					end
				end
				PH_MARK0: begin
					if (b != jfhs_pkg::BYTE_PREFIX) begin
						fin           = 1'b1;
						result.status = jfhs_pkg::STS_NO_PREFIX;
					end else begin
						phase_d = PH_MARK1;
					end
				end
				PH_MARK1: begin
					if (b == jfhs_pkg::BYTE_PREFIX) begin
						// padding byte
						if (!pad_ok) begin
							fin           = 1'b1;
							result.status = jfhs_pkg::STS_TRUNC;
						end
					end else begin
						marker_d = b;
						phase_d  = PH_LEN0;
					end
				end
				PH_LEN0: begin
					len_d   = {b, 8'h00};
					phase_d = PH_LEN1;
				end
				PH_LEN1: begin
					len_d = len_full;
					if (len_full < jfhs_pkg::MIN_SEG_LEN) begin
						fin           = 1'b1;
						result.status = jfhs_pkg::STS_BAD_LEN;
					end else if (!len_fits) begin
						fin           = 1'b1;
						result.status = jfhs_pkg::STS_TRUNC;
					end else if (is_sof) begin
						if (len_full < jfhs_pkg::MIN_SOF_LEN) begin
							fin           = 1'b1;
							result.status = jfhs_pkg::STS_BAD_LEN;
						end else begin
							idx_d   = '0;
							phase_d = PH_SOF;
						end
					end else if (len_full == jfhs_pkg::MIN_SEG_LEN) begin
						if (!room_ok) begin
							fin           = 1'b1;
							result.status = jfhs_pkg::STS_TRUNC;
						end else begin
							phase_d = PH_MARK0;
						end
					end else begin
						skip_d  = len_full - jfhs_pkg::MIN_SEG_LEN;
						phase_d = PH_SKIP;
					end
				end
				PH_SKIP: begin
					skip_d = skip_dec;
					if (skip_dec == 16'd0) begin
						if (!room_ok) begin
							fin           = 1'b1;
							result.status = jfhs_pkg::STS_TRUNC;
						end else begin
							phase_d = PH_MARK0;
						end
					end
				end
				PH_SOF: begin
					idx_d = eff_idx + 3'd1;
					case (eff_idx)
						IDX_HEIGHT_HI: height_d = {b, 8'h00};
						IDX_HEIGHT_LO: height_d = {eff_height[15:8], b};
						IDX_WIDTH_HI:  width_d  = {b, 8'h00};
						IDX_WIDTH_LO: begin
							width_d       = {eff_width[15:8], b};
							fin           = 1'b1;
							result.status = jfhs_pkg::STS_FOUND;
							result.height = eff_height;
							result.width  = {eff_width[15:8], b};
						end
						default: ;
					endcase
				end
				default: phase_d = PH_START0;
			endcase
			if (fin) begin
				done_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_size_q <= '0;
			phase_q     <= PH_START0;
			pos_q       <= '0;
			marker_q    <= '0;
			len_q       <= '0;
			skip_q      <= '0;
			idx_q       <= '0;
			height_q    <= '0;
			width_q     <= '0;
			done_q      <= 1'b1;
		end else begin
			if (cfg_wr_en) begin
				file_size_q <= cfg_wr_data;
			end
			if (step) begin
				phase_q  <= phase_d;
				pos_q    <= pos_d;
				marker_q <= marker_d;
				len_q    <= len_d;
				skip_q   <= skip_d;
				idx_q    <= idx_d;
				height_q <= height_d;
				width_q  <= width_d;
				done_q   <= done_d;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/jfhs_out_reg.sv]
`default_nettype none

module jfhs_out_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire jfhs_pkg::result_t result,
	output logic                   stall,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output jfhs_pkg::result_t      result_q
);

	// upstream holds while a result waits and is not taken
	assign stall = out_valid && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result;
		end
	end

endmodule

`default_nettype wire

[rtl/core/jpeg_frame_header_scanner.sv]
// Scans a JPEG file presented one byte per item and reports the frame size
// from the first SOF0/SOF1/SOF2 header, or an error status, as a single result
// item. A byte with first_byte set starts a new file; bytes after a result and
// before the next first byte produce nothing. Set file_size before the first
// byte of a file. One byte is accepted every cycle while the result side is not
// stalled: each byte is parsed combinationally between the input register and
// the result register, so a result is loaded as its byte leaves the input
// register. A result left waiting holds the input side after one more byte.
`default_nettype none

module jpeg_frame_header_scanner #(
	parameter int POSITION_BITS = jfhs_pkg::POSITION_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [31:0] cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        first_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic [15:0]      frame_height,
	output logic [15:0]      frame_width
);

	jfhs_pkg::in_item_t in_item, item_s1;
	jfhs_pkg::result_t  result, result_q;
	logic               valid_s1, take, stall, fin;

	assign in_item = {data_byte, first_byte};
	assign take    = valid_s1 && !stall;

	jfhs_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	jfhs_parse #(
		.POSITION_BITS (POSITION_BITS)
	) u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.step        (take),
		.item_s1     (item_s1),
		.fin         (fin),
		.result      (result)
	);

	jfhs_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take && fin),
		.result    (result),
		.stall     (stall),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result_q  (result_q)
	);

	assign status       = result_q.status;
	assign frame_height = result_q.height;
	assign frame_width  = result_q.width;

endmodule

`default_nettype wire

[rtl/core/jfhs_checker.sv]
`default_nettype none

module jfhs_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  status,
	input wire logic [15:0] frame_height,
	input wire logic [15:0] frame_width
);

	// input side only backs up behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |-> out_valid && !out_ready)
		else $error("input held without a stalled result");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= jfhs_pkg::STS_TRUNC)
		else $error("status code out of range");

	a_error_zero_dims: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != jfhs_pkg::STS_FOUND |->
			frame_height == 16'd0 && frame_width == 16'd0)
		else $error("dimensions nonzero on error result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
			$stable(frame_height) && $stable(frame_width))
		else $error("result changed while stalled");

endmodule

bind jpeg_frame_header_scanner jfhs_checker u_jfhs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status       (status),
	.frame_height (frame_height),
	.frame_width  (frame_width)
);

`default_nettype wire
